/* hw/rtl/iirtdf2_pkg.sv */
package iirtdf2_pkg;

  // fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int CELL_W      = 40;
  localparam int PROD_W      = COEF_W + SAMPLE_W;
  localparam int SUM_W       = 60;
  localparam int CFG_W       = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int TAP_COUNT_W = 4;
  localparam int COEFS_PER_WORD = CFG_W / COEF_W;

  // defaults for top-level parameters
  localparam int MAX_TAPS_DEF       = 8;
  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam logic signed [SUM_W-1:0] CELL_MAX =
    {{(SUM_W-CELL_W+1){1'b0}}, {(CELL_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] CELL_MIN =
    {{(SUM_W-CELL_W+1){1'b1}}, {(CELL_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAP_COUNT   = 3'd0,
    REG_NUM_LOW     = 3'd1,
    REG_NUM_HIGH    = 3'd2,
    REG_DEN_LOW     = 3'd3,
    REG_DEN_HIGH    = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       start_of_signal;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic clear;     // start of signal: zero the delay state
    logic load_bx;   // register b*x
    logic load_aw;   // register rounded a*w0
    logic update;    // write new delay value
    logic use_next;  // neighbor is an active cell
  } cell_ctrl_t;

  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [SUM_W-1:0] v);
    logic signed [CELL_W-1:0] r;
    if (v > CELL_MAX) begin
      r = CELL_MAX[CELL_W-1:0];
    end else if (v < CELL_MIN) begin
      r = CELL_MIN[CELL_W-1:0];
    end else begin
      r = v[CELL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/iirtdf2_cell.sv */
module iirtdf2_cell #(
  parameter int FRAC_BITS = iirtdf2_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  iirtdf2_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]     b_coef,
  input  logic signed [iirtdf2_pkg::COEF_W-1:0]     a_coef,
  input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]   x,
  input  logic signed [iirtdf2_pkg::CELL_W-1:0]     w0,
  input  logic signed [iirtdf2_pkg::CELL_W-1:0]     next_state,
  output logic signed [iirtdf2_pkg::CELL_W-1:0]     state
);

  localparam int AW_PROD_W = iirtdf2_pkg::COEF_W + iirtdf2_pkg::CELL_W;
  localparam int AW_W      = AW_PROD_W + 1 - FRAC_BITS;
  localparam logic signed [AW_PROD_W:0] HALF = (AW_PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic signed [iirtdf2_pkg::PROD_W-1:0] bx;
  logic signed [AW_W-1:0]                aw;
  logic signed [AW_PROD_W-1:0]           aw_prod;
  logic signed [AW_PROD_W:0]             aw_rounded;
  logic signed [iirtdf2_pkg::CELL_W-1:0] nxt;
  logic signed [iirtdf2_pkg::SUM_W-1:0]  sum;

  // rounding shift: floor((p + half) / 2^F) is an arithmetic shift
  assign aw_prod    = a_coef * w0;
  assign aw_rounded = (AW_PROD_W+1)'(aw_prod) + HALF;

  assign nxt = ctrl.use_next ? next_state : '0;
  assign sum = iirtdf2_pkg::SUM_W'(nxt) + iirtdf2_pkg::SUM_W'(bx)
             - iirtdf2_pkg::SUM_W'(aw);

  always_ff @(posedge clk) begin
    if (ctrl.load_bx) begin
      bx <= b_coef * x;
    end
    if (ctrl.load_aw) begin
      aw <= $signed(aw_rounded[AW_PROD_W:FRAC_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      state <= '0;
    end else if (ctrl.update) begin
      state <= iirtdf2_pkg::sat_cell(sum);
    end
  end

endmodule

/* hw/rtl/iir_filter_transposed_df2.sv */
// IIR filter, transposed direct form II, on signed 16-bit samples.
// Input channel in_valid/in_ready/in_data carries one sample and a start
// flag per transaction; output channel out_valid/out_ready/out_data returns
// one filtered sample with a clip flag for each input transaction.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes tap count
// and the packed Q3.12 coefficient words; cfg_ready is always high and
// writes are expected only while the filter is idle.
// A new sample is accepted only once the previous one has left its final
// step. Each sample walks a three-step sequence through the cell chain:
// b0*x and w0, then a[m]*w0 in every cell, then the delay update and
// output register write.
// The a*w0 multiply of each cell depends on w0, which is what sets the
// step count.
// Reset (rst, synchronous) zeroes the delay cells, the config registers and
// the handshake state. A start flag clears all cells before the sample is used.
// When the receiver stalls, the result waits in the output register and the
// next sample may be accepted and worked on; it holds in its final step
// until the output register frees up.
module iir_filter_transposed_df2 #(
  parameter int MAX_TAPS       = iirtdf2_pkg::MAX_TAPS_DEF,
  parameter int COEF_FRAC_BITS = iirtdf2_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  iirtdf2_pkg::in_t                          in_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output iirtdf2_pkg::out_t                         out_data,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [iirtdf2_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [iirtdf2_pkg::CFG_W-1:0]             cfg_data
);

  localparam int CELL_W  = iirtdf2_pkg::CELL_W;
  localparam int COEF_W  = iirtdf2_pkg::COEF_W;
  localparam int TRUNC_W = CELL_W - COEF_FRAC_BITS;
  localparam int TC_W    = iirtdf2_pkg::TAP_COUNT_W;
  localparam int CPW     = iirtdf2_pkg::COEFS_PER_WORD;
  localparam logic signed [TRUNC_W-1:0] T_MAX = TRUNC_W'(32'sd32767);
  localparam logic signed [TRUNC_W-1:0] T_MIN = TRUNC_W'(-32'sd32768);

  // configuration registers
  logic [TC_W-1:0]                 tap_count;
  logic [iirtdf2_pkg::CFG_W-1:0]   numerator_low;
  logic [iirtdf2_pkg::CFG_W-1:0]   numerator_high;
  logic [iirtdf2_pkg::CFG_W-1:0]   denominator_low;
  logic [iirtdf2_pkg::CFG_W-1:0]   denominator_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count        <= '0;
      numerator_low    <= '0;
      numerator_high   <= '0;
      denominator_low  <= '0;
      denominator_high <= '0;
    end else if (cfg_valid) begin
      unique case (iirtdf2_pkg::reg_index_t'(cfg_index))
        iirtdf2_pkg::REG_TAP_COUNT: tap_count        <= cfg_data[TC_W-1:0];
        iirtdf2_pkg::REG_NUM_LOW:   numerator_low    <= cfg_data;
        iirtdf2_pkg::REG_NUM_HIGH:  numerator_high   <= cfg_data;
        iirtdf2_pkg::REG_DEN_LOW:   denominator_low  <= cfg_data;
        iirtdf2_pkg::REG_DEN_HIGH:  denominator_high <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // effective tap count, clamped to the chain length
  logic [TC_W-1:0] n_eff;
  assign n_eff = (tap_count > TC_W'(MAX_TAPS)) ? TC_W'(MAX_TAPS) : tap_count;

  // unpack coefficients
  logic signed [COEF_W-1:0] b_coef [MAX_TAPS];
  logic signed [COEF_W-1:0] a_coef [MAX_TAPS];

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_coef
    if (i < CPW) begin : g_lo
      assign b_coef[i] = $signed(numerator_low[COEF_W*i +: COEF_W]);
      assign a_coef[i] = $signed(denominator_low[COEF_W*i +: COEF_W]);
    end else begin : g_hi
      assign b_coef[i] = $signed(numerator_high[COEF_W*(i-CPW) +: COEF_W]);
      assign a_coef[i] = $signed(denominator_high[COEF_W*(i-CPW) +: COEF_W]);
    end
  end

  // sequencer
  iirtdf2_pkg::state_t state, state_next;
  logic in_fire, finish_fire;

  assign finish_fire = (state == iirtdf2_pkg::ST_FINISH) && (!out_valid || out_ready);
  assign in_fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iirtdf2_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iirtdf2_pkg::ST_IDLE:   if (in_valid) state_next = iirtdf2_pkg::ST_HEAD;
      iirtdf2_pkg::ST_HEAD:   state_next = iirtdf2_pkg::ST_TAIL;
      iirtdf2_pkg::ST_TAIL:   state_next = iirtdf2_pkg::ST_FINISH;
      iirtdf2_pkg::ST_FINISH: if (finish_fire) state_next = iirtdf2_pkg::ST_IDLE;
      default:                state_next = iirtdf2_pkg::ST_IDLE;
    endcase
  end

  logic step_head, step_tail;

  always_comb begin
    in_ready  = 1'b0;
    step_head = 1'b0;
    step_tail = 1'b0;
    unique case (state)
      iirtdf2_pkg::ST_IDLE:   in_ready  = 1'b1;
      iirtdf2_pkg::ST_HEAD:   step_head = 1'b1;
      iirtdf2_pkg::ST_TAIL:   step_tail = 1'b1;
      iirtdf2_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // sample capture
  logic signed [iirtdf2_pkg::SAMPLE_W-1:0] x;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x <= in_data.sample_in;
    end
  end

  // delay chain: cell m holds w[m], m = 1 .. MAX_TAPS-1
  logic signed [CELL_W-1:0] cell_q [1:MAX_TAPS-1];
  logic signed [CELL_W-1:0] w0;
  logic signed [iirtdf2_pkg::PROD_W-1:0] b0x, prod0;

  assign b0x = b_coef[0] * x;

  // head: w0 = sat(w1 + b0*x); b0*x kept for the scale-only mode
  always_ff @(posedge clk) begin
    if (step_head) begin
      prod0 <= b0x;
      w0    <= iirtdf2_pkg::sat_cell(iirtdf2_pkg::SUM_W'(cell_q[1]) +
                                     iirtdf2_pkg::SUM_W'(b0x));
    end
  end

  for (genvar m = 1; m < MAX_TAPS; m++) begin : g_cell
    iirtdf2_pkg::cell_ctrl_t  ctrl;
    logic signed [CELL_W-1:0] next_state;

    if (m == MAX_TAPS - 1) begin : g_last
      assign next_state = '0;
    end else begin : g_mid
      assign next_state = cell_q[m+1];
    end

    assign ctrl.clear    = in_fire && in_data.start_of_signal;
    assign ctrl.load_bx  = step_head;
    assign ctrl.load_aw  = step_tail;
    assign ctrl.update   = finish_fire && (n_eff > TC_W'(m));
    assign ctrl.use_next = n_eff > TC_W'(m + 1);

    iirtdf2_cell #(
      .FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .b_coef     (b_coef[m]),
      .a_coef     (a_coef[m]),
      .x          (x),
      .w0         (w0),
      .next_state (next_state),
      .state      (cell_q[m])
    );
  end

  // output: cut toward zero, saturate to 16 bits; tap count 0 passes x through
  logic signed [CELL_W-1:0]  out_src;
  logic signed [TRUNC_W-1:0] trunc_val, round_up;
  iirtdf2_pkg::out_t         result;

  always_comb begin
    out_src   = (n_eff == TC_W'(1)) ? CELL_W'(prod0) : w0;
    round_up  = (out_src[CELL_W-1] && (out_src[COEF_FRAC_BITS-1:0] != '0)) ?
                TRUNC_W'(1) : '0;
    trunc_val = $signed(out_src[CELL_W-1:COEF_FRAC_BITS]) + round_up;
    if (n_eff == '0) begin
      result.sample_out = x;
      result.clipped    = 1'b0;
    end else if (trunc_val > T_MAX) begin
      result.sample_out = T_MAX[iirtdf2_pkg::SAMPLE_W-1:0];
      result.clipped    = 1'b1;
    end else if (trunc_val < T_MIN) begin
      result.sample_out = T_MIN[iirtdf2_pkg::SAMPLE_W-1:0];
      result.clipped    = 1'b1;
    end else begin
      result.sample_out = trunc_val[iirtdf2_pkg::SAMPLE_W-1:0];
      result.clipped    = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_data <= result;
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirtdf2_pkg::*;

  // filter geometry, matched to the default parameters of the block
  localparam int MAX_TAPS = MAX_TAPS_DEF;
  localparam int FRAC     = COEF_FRAC_BITS_DEF;

  // delay cells saturate to signed 40 bits
  localparam longint CELL_HI = (longint'(1) <<< (CELL_W - 1)) - 1;
  localparam longint CELL_LO = -(longint'(1) <<< (CELL_W - 1));

  // indexes past the last register: writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int HOLDOFF_LEN  = 400;   // long receiver stall
  localparam int DRAIN_CYCLES = 16;    // wait after the last result before the final check
  localparam int IDLE_PCT     = 15;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_W-1:0]       data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  // shadow of the filter registers and delay line
  logic [TAP_COUNT_W-1:0] tap_count_q = '0;
  logic [CFG_W-1:0]       num_lo_q    = '0;
  logic [CFG_W-1:0]       num_hi_q    = '0;
  logic [CFG_W-1:0]       den_lo_q    = '0;
  logic [CFG_W-1:0]       den_hi_q    = '0;
  longint                 delay_q[MAX_TAPS] = '{default: 0};

  in_t  stim_q[$];        // samples waiting to be offered
  out_t pcm_expected[$];  // predicted filter outputs, oldest first

  int   mismatches   = 0;
  bit   calm         = 1'b0;  // no idling on either side while set
  int   holdoff_req  = 0;     // bumped to ask the receiver for a long stall
  int   holdoff_seen = 0;
  int   holdoff_left = 0;

  int   taps_list[10] = '{2, 8, 3, 15, 5, 0, 4, 7, 1, 6};

  iir_filter_transposed_df2 uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Filter arithmetic
  // ---------------------------------------------------------------------

  // coefficient i out of a pair of packed words, sign extended
  function automatic longint tap_coef(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, int i);
    logic [CFG_W-1:0]  word;
    logic [COEF_W-1:0] raw;
    word = (i < COEFS_PER_WORD) ? lo : hi;
    raw  = word[COEF_W*(i % COEFS_PER_WORD) +: COEF_W];
    return longint'($signed(raw));
  endfunction

  function automatic longint clamp_cell(longint v);
    if (v > CELL_HI) return CELL_HI;
    if (v < CELL_LO) return CELL_LO;
    return v;
  endfunction

  // drop the fraction toward zero, then clip to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] to_pcm(longint w, output logic clip);
    longint t;
    t = (w >= 0) ? (w >>> FRAC) : -((-w) >>> FRAC);
    clip = 1'b0;
    if (t > 32767) begin
      t = 32767;
      clip = 1'b1;
    end
    if (t < -32768) begin
      t = -32768;
      clip = 1'b1;
    end
    return t[SAMPLE_W-1:0];
  endfunction

  // One sample through the transposed DF2 chain; updates the shadow delay line.
  function automatic out_t filter_step(in_t item);
    longint x, w0, nxt, bx, aw;
    int     n;
    logic   clip;
    out_t   r;
    x    = longint'($signed(item.sample_in));
    n    = (tap_count_q > MAX_TAPS) ? MAX_TAPS : int'(tap_count_q);
    clip = 1'b0;
    // start of signal wipes every cell, whatever the mode
    if (item.start_of_signal) begin
      foreach (delay_q[i]) delay_q[i] = 0;
    end
    if (n == 0) begin
      r.sample_out = item.sample_in;
    end else if (n == 1) begin
      // scale only, no a0 division, cells left alone
      r.sample_out = to_pcm(tap_coef(num_lo_q, num_hi_q, 0) * x, clip);
    end else begin
      w0 = clamp_cell(delay_q[1] + tap_coef(num_lo_q, num_hi_q, 0) * x);
      delay_q[0] = w0;
      // ascending order: delay_q[m+1] still holds the previous sample's value
      for (int m = 1; m < n; m++) begin
        nxt = (m + 1 < n) ? delay_q[m+1] : 0;
        bx  = tap_coef(num_lo_q, num_hi_q, m) * x;
        // round half up on the feedback product
        aw  = (tap_coef(den_lo_q, den_hi_q, m) * w0 + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        delay_q[m] = clamp_cell(nxt + bx - aw);
      end
      r.sample_out = to_pcm(w0, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [CFG_W-1:0] pack4(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                             logic [COEF_W-1:0] c2, logic [COEF_W-1:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  // wild: any 16-bit value; otherwise a stable-ish range (small feedback)
  function automatic logic [CFG_W-1:0] coef_word(bit den, bit wild);
    logic [CFG_W-1:0] w;
    int v;
    for (int i = 0; i < COEFS_PER_WORD; i++) begin
      if (wild) v = int'($urandom_range(16'hFFFF));
      else if (den) v = int'($urandom_range(16'h480)) - 16'h240;
      else v = int'($urandom_range(16'h2000)) - 16'h1000;
      w[COEF_W*i +: COEF_W] = v[COEF_W-1:0];
    end
    return w;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r, v;
    r = int'($urandom_range(99));
    if (r < 10) return 16'h7FFF;
    if (r < 20) return 16'h8000;
    if (r < 35) begin
      v = int'($urandom_range(64)) - 32;
      return v[SAMPLE_W-1:0];
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic add_item(logic [SAMPLE_W-1:0] s, bit sos);
    in_t item;
    item.sample_in       = s;
    item.start_of_signal = sos;
    stim_q.push_back(item);
  endtask

  task automatic random_burst(int count, bit sos_first);
    for (int i = 0; i < count; i++) begin
      add_item(pick_sample(), (i == 0 && sos_first) || ($urandom_range(99) < 2));
    end
  endtask

  // returns at a falling edge once everything offered has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || pcm_expected.size() != 0);
  endtask

  // Program the filter while it is idle. cfg_valid stays up across
  // back-to-back writes and drops only after the last one.
  task automatic set_filter(logic [TAP_COUNT_W-1:0] taps, logic [CFG_W-1:0] nl,
                            logic [CFG_W-1:0] nh, logic [CFG_W-1:0] dl,
                            logic [CFG_W-1:0] dh, bit spare);
    reg_write_t writes[$];
    reg_write_t w;
    logic [31:0] junk;
    if (spare) begin
      w.idx  = CFG_INDEX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
      w.data = {$urandom, $urandom};
      writes.push_back(w);
    end
    // upper bits of the tap count word are don't-care
    junk = $urandom;
    w.idx = REG_TAP_COUNT;  w.data = {$urandom, junk[31:TAP_COUNT_W], taps};
    writes.push_back(w);
    w.idx = REG_NUM_LOW;    w.data = nl;  writes.push_back(w);
    w.idx = REG_NUM_HIGH;   w.data = nh;  writes.push_back(w);
    w.idx = REG_DEN_LOW;    w.data = dl;  writes.push_back(w);
    w.idx = REG_DEN_HIGH;   w.data = dh;  writes.push_back(w);

    wait_drained();
    @(posedge clk);
    foreach (writes[i]) begin
      cfg_index <= writes[i].idx;
      cfg_data  <= writes[i].data;
      cfg_valid <= 1'b1;
      do @(posedge clk);
      while (!cfg_ready);
      case (writes[i].idx)
        REG_TAP_COUNT: tap_count_q = writes[i].data[TAP_COUNT_W-1:0];
        REG_NUM_LOW:   num_lo_q    = writes[i].data;
        REG_NUM_HIGH:  num_hi_q    = writes[i].data;
        REG_DEN_LOW:   den_lo_q    = writes[i].data;
        REG_DEN_HIGH:  den_hi_q    = writes[i].data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued samples, random gaps unless calm
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // current transaction done (or none): pick the next one or idle
      if (stim_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every input transaction, checks every output
  // transaction in order, and drives the receiver's ready.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pcm_expected.push_back(filter_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (pcm_expected.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected output: sample %0d clipped %0b",
                     $signed(out_data.sample_out), out_data.clipped);
          end
          mismatches++;
        end else begin
          want = pcm_expected.pop_front();
          if (out_data.sample_out !== want.sample_out || out_data.clipped !== want.clipped) begin
            if (mismatches < 10) begin
              $display("mismatch: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                       $signed(want.sample_out), want.clipped,
                       $signed(out_data.sample_out), out_data.clipped);
            end
            mismatches++;
          end
        end
      end
      // long stall on request, counted here; otherwise random back-pressure
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without any transaction means a hang
  // ---------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    bit wild;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at reset: tap count 0, pass-through
    add_item(16'h7FFF, 1'b1);
    add_item(16'h8000, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'hFFFF, 1'b0);
    add_item(16'h0001, 1'b0);

    // scale only, largest b0: clipping both ways, truncation toward zero
    set_filter(4'd1, pack4(16'h7FFF, 16'h0000, 16'h0000, 16'h0000), '0,
               pack4(16'h1234, 16'h0000, 16'h0000, 16'h0000), '0, 1'b1);
    add_item(16'h7FFF, 1'b0);
    add_item(16'h8000, 1'b1);
    add_item(16'h1000, 1'b0);
    add_item(16'hF000, 1'b0);
    add_item(16'h0003, 1'b0);
    add_item(16'hFFFD, 1'b0);

    // scale only, most negative b0
    set_filter(4'd1, pack4(16'h8000, 16'h0000, 16'h0000, 16'h0000), '0, '0, '0, 1'b0);
    add_item(16'h8000, 1'b0);
    add_item(16'h7FFF, 1'b0);
    add_item(16'h0001, 1'b0);
    add_item(16'hFFFF, 1'b0);

    // full eight taps, gentle coefficients: impulse response
    set_filter(4'd8, coef_word(1'b0, 1'b0), coef_word(1'b0, 1'b0),
               coef_word(1'b1, 1'b0), coef_word(1'b1, 1'b0), 1'b0);
    add_item(16'h7FFF, 1'b1);
    add_item(16'h0000, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'h8000, 1'b0);

    // tap count above the maximum, extreme coefficients: cells run into saturation
    set_filter(4'd15, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h8000}}, 1'b1);
    add_item(16'h7FFF, 1'b1);
    add_item(16'h7FFF, 1'b0);
    add_item(16'h8000, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'h0000, 1'b1);

    // random phases; cells carry over between phases unless the first
    // sample restarts the signal, so tap count changes mid-stream get hit
    for (int p = 0; p < 10; p++) begin
      wild = (p == 3 || p == 6);
      set_filter(TAP_COUNT_W'(taps_list[p]), coef_word(1'b0, wild), coef_word(1'b0, wild),
                 coef_word(1'b1, wild), coef_word(1'b1, wild), (p % 3) == 0);
      calm = (p == 2);
      if (p == 1) holdoff_req++;  // output stalls while input keeps coming
      if (p == 4) begin
        // sender stops halfway until the pipe is empty
        random_burst(76, 1'b1);
        wait_drained();
        random_burst(77, 1'b0);
      end else begin
        random_burst(153, (p % 2) == 0);
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pcm_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
